>>> design/ckp_pkg.sv
package ckp_pkg;

    localparam int BASE_CHAR_W  = 8;
    localparam int KMER_LEN_W   = 6;
    localparam int CODE_FIELD_W = 64;
    localparam int M_TDATA_W    = 3 * CODE_FIELD_W;
    localparam int MAX_KMER_DEF = 32;
    localparam int KMER_RESET   = 32;

    localparam logic [BASE_CHAR_W-1:0] CHAR_G_UC = 8'h47;
    localparam logic [BASE_CHAR_W-1:0] CHAR_G_LC = 8'h67;
    localparam logic [BASE_CHAR_W-1:0] CHAR_A_UC = 8'h41;
    localparam logic [BASE_CHAR_W-1:0] CHAR_A_LC = 8'h61;
    localparam logic [BASE_CHAR_W-1:0] CHAR_T_UC = 8'h54;
    localparam logic [BASE_CHAR_W-1:0] CHAR_T_LC = 8'h74;
    localparam logic [BASE_CHAR_W-1:0] CHAR_C_UC = 8'h43;
    localparam logic [BASE_CHAR_W-1:0] CHAR_C_LC = 8'h63;

    localparam logic [1:0] CODE_G = 2'd0;
    localparam logic [1:0] CODE_A = 2'd1;
    localparam logic [1:0] CODE_T = 2'd2;
    localparam logic [1:0] CODE_C = 2'd3;

    typedef struct packed {
        logic       bad;
        logic [1:0] code;
    } base_code_t;

    // unknown characters pack as C and raise the flag
    function automatic base_code_t map_base(input logic [BASE_CHAR_W-1:0] ch);
        base_code_t r;
        r.bad = 1'b0;
        unique case (ch)
            CHAR_G_UC, CHAR_G_LC: r.code = CODE_G;
            CHAR_A_UC, CHAR_A_LC: r.code = CODE_A;
            CHAR_T_UC, CHAR_T_LC: r.code = CODE_T;
            CHAR_C_UC, CHAR_C_LC: r.code = CODE_C;
            default: begin
                r.code = CODE_C;
                r.bad  = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

>>> design/canonical_kmer_packer_unit.sv
// channel   direction  tdata (lsb up)                               tuser
// s_        in         base_char[7:0]                               -
// m_        out        forward[63:0] revcomp[127:64] canon[191:128] has_invalid
// cfg_      in         kmer_size[5:0] on cfg_wdata, cfg_we strobe   -
//
// one word per cycle in and out while the output is not stalled; a base is
// held in the input register, and the k-mer result is loaded into the output
// register when its last base leaves the input register (no bubbles)
// the only combinational depth is the base map, a two-bit shift, a lane
// decode for the reverse complement and one 2*MAX_KMER-bit compare
// aresetn (synchronous, active low) empties both registers, clears the
// accumulators and sets kmer_size to its reset value
// a stalled result blocks only the word that would complete the next k-mer
module canonical_kmer_packer_unit #(
    parameter int MAX_KMER = ckp_pkg::MAX_KMER_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration: kmer_size
    input  logic                             cfg_we,
    input  logic [ckp_pkg::KMER_LEN_W-1:0]   cfg_wdata,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ckp_pkg::BASE_CHAR_W-1:0]  s_tdata,   // base_char
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ckp_pkg::M_TDATA_W-1:0]    m_tdata,   // forward, revcomp, canonical
    output logic                             m_tuser    // has_invalid
);
    import ckp_pkg::*;

    localparam int ACC_W = 2 * MAX_KMER;
    localparam int CNT_W = $clog2(MAX_KMER + 1);
    localparam int LEN_RESET = (KMER_RESET > MAX_KMER) ? MAX_KMER : KMER_RESET;

    // effective length, already clamped to 1..MAX_KMER
    logic [CNT_W-1:0]       len_reg;

    // input register
    logic                   in_valid_reg;
    logic [BASE_CHAR_W-1:0] in_char_reg;

    // k-mer accumulators
    logic [ACC_W-1:0]       fwd_reg, fwd_next;
    logic [ACC_W-1:0]       rev_reg, rev_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   invalid_reg, invalid_next;

    // output register
    logic                   out_valid_reg;
    logic [M_TDATA_W-1:0]   out_data_reg;
    logic                   out_invalid_reg;

    base_code_t             base;
    logic [1:0]             comp;
    logic                   done;
    logic                   advance;
    logic [ACC_W-1:0]       rev_shift;
    logic [ACC_W-1:0]       canon;

    always_comb begin
        base       = map_base(in_char_reg);
        comp       = 2'd3 - base.code;
        fwd_next   = (fwd_reg << 2) | ACC_W'(base.code);
        rev_shift  = rev_reg >> 2;
        // the new complement lands in the lane of the k-th base
        for (int i = 0; i < MAX_KMER; i++) begin
            rev_next[2*i +: 2] = rev_shift[2*i +: 2]
                | ((CNT_W'(i + 1) == len_reg) ? comp : 2'd0);
        end
        count_next   = count_reg + CNT_W'(1);
        invalid_next = invalid_reg | base.bad;
        done         = (count_next >= len_reg);
        canon        = (rev_next > fwd_next) ? rev_next : fwd_next;
    end

    // a word that completes a k-mer needs room in the output register
    assign advance  = in_valid_reg && (!done || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= CNT_W'(LEN_RESET);
        end else if (cfg_we) begin
            if (cfg_wdata == '0) begin
                len_reg <= CNT_W'(1);
            end else if (int'(cfg_wdata) > MAX_KMER) begin
                len_reg <= CNT_W'(MAX_KMER);
            end else begin
                len_reg <= CNT_W'(cfg_wdata);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
        end
    end

    // accumulators restart after each k-mer and on a length write
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            fwd_reg     <= '0;
            rev_reg     <= '0;
            count_reg   <= '0;
            invalid_reg <= 1'b0;
        end else if (advance) begin
            if (done) begin
                fwd_reg     <= '0;
                rev_reg     <= '0;
                count_reg   <= '0;
                invalid_reg <= 1'b0;
            end else begin
                fwd_reg     <= fwd_next;
                rev_reg     <= rev_next;
                count_reg   <= count_next;
                invalid_reg <= invalid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && done) begin
            out_data_reg    <= {CODE_FIELD_W'(canon), CODE_FIELD_W'(rev_next),
                                CODE_FIELD_W'(fwd_next)};
            out_invalid_reg <= invalid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_invalid_reg;

    // a partial k-mer never reaches the length
    a_count_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < len_reg)
        else $error("base count reached k-mer length");

    // canonical word is one of the two codes
    a_canon_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3*CODE_FIELD_W-1:2*CODE_FIELD_W] == m_tdata[CODE_FIELD_W-1:0])
                  || (m_tdata[3*CODE_FIELD_W-1:2*CODE_FIELD_W]
                      == m_tdata[2*CODE_FIELD_W-1:CODE_FIELD_W]))
        else $error("canonical word matches neither strand");

    // a held base waits in the input register untouched
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !s_tready |=> in_valid_reg && $stable(in_char_reg))
        else $error("stalled base lost or changed");

    // a length write starts a fresh k-mer
    a_cfg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> count_reg == '0 && !invalid_reg)
        else $error("k-mer state not cleared by length write");

endmodule

>>> tb/canonical_kmer_packer_unit_test.sv
`timescale 1ns / 100ps

module canonical_kmer_packer_unit_test;

    import ckp_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int MAX_BASES    = MAX_KMER_DEF;
    // long receiver hold-off, well past what the block can buffer
    localparam int HOLD_CYCLES  = 200;
    // settle time after the last k-mer: covers words still in the input register
    localparam int SETTLE       = 6;

    // one k-mer result as it should leave the block
    typedef struct {
        logic [CODE_FIELD_W-1:0] fwd;
        logic [CODE_FIELD_W-1:0] rev;
        logic [CODE_FIELD_W-1:0] canon;
        logic                    inv;
    } kmer_result_t;

    // the eight accepted spellings, upper case first
    localparam logic [BASE_CHAR_W-1:0] BASE_CHARS [8] = '{
        CHAR_G_UC, CHAR_A_UC, CHAR_T_UC, CHAR_C_UC,
        CHAR_G_LC, CHAR_A_LC, CHAR_T_LC, CHAR_C_LC
    };

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [KMER_LEN_W-1:0]     cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [BASE_CHAR_W-1:0]    s_tdata   = '0;   // base_char
    logic                      m_tvalid;
    logic                      m_tready  = 1'b1;
    logic [M_TDATA_W-1:0]      m_tdata;          // forward, revcomp, canonical
    logic                      m_tuser;          // has_invalid

    // predictor state, mirrors the block's accumulators and register
    logic [KMER_LEN_W-1:0]     kmer_len_reg = KMER_RESET[KMER_LEN_W-1:0];
    logic [CODE_FIELD_W-1:0]   fwd_acc      = '0;
    logic [CODE_FIELD_W-1:0]   rev_acc      = '0;
    logic [KMER_LEN_W-1:0]     bases_held   = '0;
    logic                      invalid_held = 1'b0;

    kmer_result_t kmers_due[$];

    // stimulus and receiver controls
    bit  idle_on       = 1'b1;
    int  hold_requests = 0;
    int  holds_served  = 0;
    int  hold_left     = 0;
    int  stall_left    = 0;

    // bookkeeping for the summary
    int  errors         = 0;
    int  bases_sent     = 0;
    int  kmers_checked  = 0;
    int  length_writes  = 0;

    canonical_kmer_packer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // bases per k-mer after the zero and over-range corrections
    function automatic int kmer_bases(input logic [KMER_LEN_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > MAX_BASES)
            return MAX_BASES;
        return int'(len);
    endfunction

    function automatic void clear_kmer_state();
        fwd_acc      = '0;
        rev_acc      = '0;
        bases_held   = '0;
        invalid_held = 1'b0;
    endfunction

    // fold one accepted base into the k-mer; queue a result on its last base
    function automatic void pack_base(input logic [BASE_CHAR_W-1:0] ch);
        logic [1:0]              code;
        logic [1:0]              comp;
        int                      k;
        kmer_result_t            res;
        k = kmer_bases(kmer_len_reg);
        case (ch)
            CHAR_G_UC, CHAR_G_LC: code = CODE_G;
            CHAR_A_UC, CHAR_A_LC: code = CODE_A;
            CHAR_T_UC, CHAR_T_LC: code = CODE_T;
            CHAR_C_UC, CHAR_C_LC: code = CODE_C;
            default: begin
                // unknown byte packs as C and marks the k-mer
                code = CODE_C;
                invalid_held = 1'b1;
            end
        endcase
        comp = CODE_C - code;
        fwd_acc = {fwd_acc[CODE_FIELD_W-3:0], code};
        // complement enters at the top lane of this k-mer and walks down
        rev_acc = (rev_acc >> 2)
                | ({{(CODE_FIELD_W-2){1'b0}}, comp} << (2 * (k - 1)));
        bases_held = bases_held + 1'b1;
        if (int'(bases_held) >= k) begin
            res.fwd   = fwd_acc;
            res.rev   = rev_acc;
            res.canon = (rev_acc > fwd_acc) ? rev_acc : fwd_acc;
            res.inv   = invalid_held;
            kmers_due.push_back(res);
            clear_kmer_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // receiver: random stall bursts plus the requested long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bit ready_next;
        ready_next = 1'b1;
        if (!aresetn) begin
            hold_left  = 0;
            stall_left = 0;
        end else begin
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                ready_next = 1'b0;
            end
        end
        m_tready <= ready_next;
    end

    // ------------------------------------------------------------------
    // result checker: every word against the oldest expected k-mer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        kmer_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (kmers_due.size() == 0) begin
                $display("%0t: unexpected result word fwd=%h rev=%h canon=%h inv=%b",
                         $time, m_tdata[63:0], m_tdata[127:64], m_tdata[191:128],
                         m_tuser);
                errors++;
            end else begin
                want = kmers_due.pop_front();
                kmers_checked++;
                if (m_tdata[63:0] !== want.fwd) begin
                    $display("%0t: forward mismatch expected %h actual %h",
                             $time, want.fwd, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[127:64] !== want.rev) begin
                    $display("%0t: revcomp mismatch expected %h actual %h",
                             $time, want.rev, m_tdata[127:64]);
                    errors++;
                end
                if (m_tdata[191:128] !== want.canon) begin
                    $display("%0t: canonical mismatch expected %h actual %h",
                             $time, want.canon, m_tdata[191:128]);
                    errors++;
                end
                if (m_tuser !== want.inv) begin
                    $display("%0t: invalid flag mismatch expected %b actual %b",
                             $time, want.inv, m_tuser);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // shared stimulus tasks, each entered and left on a rising edge
    // ------------------------------------------------------------------

    // offer one base, wait for the handshake, then predict; valid stays up
    task automatic send_base(input logic [BASE_CHAR_W-1:0] ch);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bases_sent++;
        pack_base(ch);
    endtask

    // drop valid and let every pending k-mer come out, then let the pipe settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (kmers_due.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // register write only once the block has gone quiet
    task automatic write_kmer_size(input logic [KMER_LEN_W-1:0] len);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge aclk);
        // a write drops any half-built k-mer
        kmer_len_reg = len;
        clear_kmer_state();
        length_writes++;
        cfg_we <= 1'b0;
    endtask

    // mostly clean bases in either case, about one in eight any byte at all
    function automatic logic [BASE_CHAR_W-1:0] pick_base();
        int r;
        r = $urandom_range(0, 15);
        if (r < 14)
            return BASE_CHARS[r % 8];
        return BASE_CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic send_random_bases(input int n);
        repeat (n) send_base(pick_base());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // length straight out of reset, no register write
    task automatic test_reset_length();
        send_random_bases(2 * KMER_RESET);
    endtask

    // one-base k-mers: every spelling, the byte extremes and a near miss
    task automatic test_base_map();
        write_kmer_size(KMER_LEN_W'(1));
        foreach (BASE_CHARS[i])
            send_base(BASE_CHARS[i]);
        send_base(8'h00);
        send_base(8'hFF);
        send_base(8'h40);
    endtask

    // zero length behaves as one base
    task automatic test_zero_length();
        write_kmer_size('0);
        send_base(CHAR_A_UC);
        send_base(CHAR_C_LC);
    endtask

    // half-built k-mer thrown away by a new length
    task automatic test_partial_discard();
        write_kmer_size(KMER_LEN_W'(5));
        send_base(CHAR_T_UC);
        send_base(8'h2A);
        send_base(CHAR_G_UC);
        write_kmer_size(KMER_LEN_W'(3));
        send_base(CHAR_A_UC);
        send_base(CHAR_T_LC);
        send_base(CHAR_G_UC);
    endtask

    // walk the register from the smallest to past the top, random ones too
    task automatic test_length_sweep();
        logic [KMER_LEN_W-1:0] lens [12] = '{
            6'd0, 6'd1, 6'd2, 6'd3, 6'd5, 6'd8, 6'd16, 6'd31, 6'd32, 6'd33, 6'd48, 6'd63
        };
        int k;
        foreach (lens[i]) begin
            write_kmer_size(lens[i]);
            k = kmer_bases(lens[i]);
            // at least three k-mers each; any ragged tail is dropped by the next write
            send_random_bases((3 * k > 40) ? 3 * k : 40);
        end
        repeat (3) begin
            write_kmer_size(KMER_LEN_W'($urandom_range(1, 12)));
            send_random_bases(20);
        end
    endtask

    // receiver holds off long enough for the block to back up into its input
    task automatic test_backpressure();
        write_kmer_size(KMER_LEN_W'(2));
        idle_on = 1'b0;
        hold_requests++;
        send_random_bases(60);
        idle_on = 1'b1;
    endtask

    // last stretch at full rate on both sides
    task automatic test_full_rate();
        write_kmer_size(KMER_LEN_W'(4));
        idle_on = 1'b0;
        send_random_bases(40);
        write_kmer_size(KMER_LEN_W'(1));
        send_random_bases(20);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_length();
        test_base_map();
        test_zero_length();
        test_partial_discard();
        test_length_sweep();
        test_backpressure();
        test_full_rate();

        drain_results();

        $display("run covered %0d bases and %0d k-mers over %0d length settings",
                 bases_sent, kmers_checked, length_writes + 1);
        $display("lengths from zero to above the maximum, invalid bytes, long stall");
        if (errors == 0 && kmers_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d errors, %0d k-mers never seen", errors, kmers_due.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("timeout with %0d k-mers outstanding", kmers_due.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
design/ckp_pkg.sv
design/canonical_kmer_packer_unit.sv
tb/canonical_kmer_packer_unit_test.sv
